FILE: rtl/core/svss_pkg.sv
// Package of the surrounding vehicle slot selector: field widths, zone and
// register codes, reset values and the structs passed between the modules.
// No dependencies.
package svss_pkg;

	// Field widths
	localparam int LAT_W    = 10;
	localparam int SPD_W    = 13;
	localparam int GAP_W    = 16;
	localparam int VD_W     = SPD_W + 1;
	localparam int DIST_W   = 16;
	localparam int OBJ_W    = 6;
	localparam int ZONE_W   = 3;
	localparam int LANE_W   = 3;
	localparam int CFG_W    = 15;
	localparam int HW_W     = 8;
	localparam int PROD_W   = HW_W + SPD_W;
	localparam int CMP_W    = 24;
	localparam int IDX_W    = 3;

	localparam int ZONE_COUNT = 8;

	// Lane is (lateral + 3 lane widths) / lane width, all in 1/64 m
	localparam int LANE_OFFSET = 768;
	localparam int LANE_SHIFT  = 8;

	// Fixed 3 s headway, Q4.4
	localparam int FIXED_HEADWAY = 48;

	typedef enum logic [ZONE_W-1:0] {
		ZONE_LEFT_REAR    = 3'd0,
		ZONE_LEFT_BESIDE  = 3'd1,
		ZONE_LEFT_FRONT   = 3'd2,
		ZONE_FRONT        = 3'd3,
		ZONE_RIGHT_FRONT  = 3'd4,
		ZONE_RIGHT_BESIDE = 3'd5,
		ZONE_RIGHT_REAR   = 3'd6,
		ZONE_REAR         = 3'd7
	} zone_t;

	typedef enum logic [IDX_W-1:0] {
		CFG_FRONT_GAP         = 3'd0,
		CFG_REAR_GAP          = 3'd1,
		CFG_SIDE_GAP          = 3'd2,
		CFG_SIDE_REAR_MARGIN  = 3'd3,
		CFG_RANGE_LIMIT       = 3'd4,
		CFG_FRONT_HEADWAY     = 3'd5,
		CFG_SIDE_HEADWAY      = 3'd6,
		CFG_SIDE_REAR_HEADWAY = 3'd7
	} cfg_idx_t;

	typedef enum logic [1:0] {
		LANE_SAME,
		LANE_LEFT,
		LANE_RIGHT,
		LANE_OTHER
	} lane_rel_t;

	// Register reset values
	localparam logic [CFG_W-1:0] FRONT_GAP_RST        = 15'd1920;
	localparam logic [CFG_W-1:0] REAR_GAP_RST         = 15'd1920;
	localparam logic [CFG_W-1:0] SIDE_GAP_RST         = 15'd640;
	localparam logic [CFG_W-1:0] SIDE_REAR_MARGIN_RST = 15'd256;
	localparam logic [CFG_W-1:0] RANGE_LIMIT_RST      = 15'd12800;
	localparam logic [HW_W-1:0]  FRONT_HEADWAY_RST    = 8'd48;
	localparam logic [HW_W-1:0]  SIDE_HEADWAY_RST     = 8'd3;
	localparam logic [HW_W-1:0]  SIDE_REAR_HW_RST     = 8'd16;

	typedef struct packed {
		logic [CFG_W-1:0] front_gap;
		logic [CFG_W-1:0] rear_gap;
		logic [CFG_W-1:0] side_gap;
		logic [CFG_W-1:0] side_rear_margin;
		logic [CFG_W-1:0] range_limit;
		logic [HW_W-1:0]  front_headway;
		logic [HW_W-1:0]  side_headway;
		logic [HW_W-1:0]  side_rear_headway;
	} cfg_t;

	// Per-object features after the first stage
	typedef struct packed {
		logic signed [GAP_W-1:0] gap;
		logic signed [VD_W-1:0]  vd;
		lane_rel_t               rel;
		logic [PROD_W-1:0]       fh_prod;
		logic [PROD_W-1:0]       sh_prod;
		logic [PROD_W-1:0]       srh_prod;
		logic [PROD_W-1:0]       fx_prod;
		logic                    frame_end;
	} feat_t;

	// Zone decision for one object
	typedef struct packed {
		logic              hit;
		zone_t             zone;
		logic [DIST_W-1:0] abs_gap;
	} cls_t;

	// Frame result handed to the output buffer
	typedef struct packed {
		logic [ZONE_COUNT-1:0]            found;
		logic [ZONE_COUNT-1:0][OBJ_W-1:0] obj;
	} snap_t;

endpackage

FILE: rtl/core/svss_if.sv
// Channel interfaces of the slot selector: object words in, zone words out.
// Depends on svss_pkg for field widths.
interface svss_obj_if;
	logic                             valid;
	logic                             ready;
	logic [svss_pkg::LAT_W-1:0]       ego_lateral;
	logic [svss_pkg::SPD_W-1:0]       ego_speed;
	logic signed [svss_pkg::GAP_W-1:0] object_gap;
	logic [svss_pkg::LAT_W-1:0]       object_lateral;
	logic [svss_pkg::SPD_W-1:0]       object_speed;
	logic                             frame_end;

	modport source (output valid, ego_lateral, ego_speed, object_gap, object_lateral,
		object_speed, frame_end, input ready);
	modport sink (input valid, ego_lateral, ego_speed, object_gap, object_lateral,
		object_speed, frame_end, output ready);
endinterface

interface svss_slot_if;
	logic                        valid;
	logic                        ready;
	logic [svss_pkg::ZONE_W-1:0] zone;
	logic                        found;
	logic [svss_pkg::OBJ_W-1:0]  object_number;
	logic                        zone_last;

	modport source (output valid, zone, found, object_number, zone_last, input ready);
	modport sink (input valid, zone, found, object_number, zone_last, output ready);
endinterface

FILE: rtl/core/surrounding_vehicle_slot_select_unit.sv
// Top level of the surrounding vehicle slot selector.
// Depends on svss_pkg, svss_if, svss_classify, svss_zone_table, svss_drain.
//
//   channel   dir   word                                           when
//   objects   in    one tracked object (ego + object, frame_end)   valid && ready
//   slots     out   one zone result (zone, found, object_number)   valid && ready
//   cfg       in    register write (cfg_index, cfg_wdata)          cfg_we
//
// One object word is taken every cycle unless a frame end waits in stage 2.
// Stage 1 registers the word, stage 2 holds lane relation and headway
// products, and the zone table updates as the word leaves stage 2. The last
// object of a frame loads the output buffer, whose eight zone words leave
// one per cycle while slots is ready. A frame end that reaches stage 2 while
// the buffer still drains waits there and backs up the input. arst_n clears
// the zone valid bits, counter and pipeline valids and resets the registers
// to their reset values; a stalled slots channel holds its word.
module surrounding_vehicle_slot_select_unit #(
	parameter int MAX_OBJECTS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [svss_pkg::IDX_W-1:0]    cfg_index,
	input  logic [svss_pkg::CFG_W-1:0]    cfg_wdata,
	svss_obj_if.sink                      objects,
	svss_slot_if.source                   slots
);
	localparam int PW = svss_pkg::PROD_W;

	svss_pkg::cfg_t  cfg_q;
	svss_pkg::feat_t feat_s2, feat_d;
	svss_pkg::cls_t  cls;
	svss_pkg::snap_t snap;

	logic valid_s1, valid_s2;
	logic ld_s1, ld_s2, adv_s2, busy;

	logic [svss_pkg::LAT_W-1:0]        ego_lat_s1, obj_lat_s1;
	logic [svss_pkg::SPD_W-1:0]        ego_spd_s1, obj_spd_s1;
	logic signed [svss_pkg::GAP_W-1:0] gap_s1;
	logic                              end_s1;

	logic [svss_pkg::LANE_W-1:0] lane_ego, lane_obj;
	logic [svss_pkg::LANE_W:0]   lane_ego_x, lane_obj_x;
	logic [svss_pkg::SPD_W-1:0]  vmax;
	logic [PW-1:0]               vmax_x;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.front_gap         <= svss_pkg::FRONT_GAP_RST;
			cfg_q.rear_gap          <= svss_pkg::REAR_GAP_RST;
			cfg_q.side_gap          <= svss_pkg::SIDE_GAP_RST;
			cfg_q.side_rear_margin  <= svss_pkg::SIDE_REAR_MARGIN_RST;
			cfg_q.range_limit       <= svss_pkg::RANGE_LIMIT_RST;
			cfg_q.front_headway     <= svss_pkg::FRONT_HEADWAY_RST;
			cfg_q.side_headway      <= svss_pkg::SIDE_HEADWAY_RST;
			cfg_q.side_rear_headway <= svss_pkg::SIDE_REAR_HW_RST;
		end else if (cfg_we) begin
			case (svss_pkg::cfg_idx_t'(cfg_index))
				svss_pkg::CFG_FRONT_GAP:         cfg_q.front_gap <= cfg_wdata;
				svss_pkg::CFG_REAR_GAP:          cfg_q.rear_gap <= cfg_wdata;
				svss_pkg::CFG_SIDE_GAP:          cfg_q.side_gap <= cfg_wdata;
				svss_pkg::CFG_SIDE_REAR_MARGIN:  cfg_q.side_rear_margin <= cfg_wdata;
				svss_pkg::CFG_RANGE_LIMIT:       cfg_q.range_limit <= cfg_wdata;
				svss_pkg::CFG_FRONT_HEADWAY:     cfg_q.front_headway <= cfg_wdata[svss_pkg::HW_W-1:0];
				svss_pkg::CFG_SIDE_HEADWAY:      cfg_q.side_headway <= cfg_wdata[svss_pkg::HW_W-1:0];
				svss_pkg::CFG_SIDE_REAR_HEADWAY: begin
					cfg_q.side_rear_headway <= cfg_wdata[svss_pkg::HW_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Pipeline flow: only a frame end waiting on a busy buffer stalls
	assign adv_s2 = valid_s2 && !(feat_s2.frame_end && busy);
	assign ld_s2  = !valid_s2 || adv_s2;
	assign ld_s1  = !valid_s1 || ld_s2;
	assign objects.ready = ld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ld_s1) valid_s1 <= objects.valid;
			if (ld_s2) valid_s2 <= valid_s1;
		end
	end

	// Stage 1: capture the object word
	always_ff @(posedge clk) begin
		if (ld_s1 && objects.valid) begin
			ego_lat_s1 <= objects.ego_lateral;
			ego_spd_s1 <= objects.ego_speed;
			gap_s1     <= objects.object_gap;
			obj_lat_s1 <= objects.object_lateral;
			obj_spd_s1 <= objects.object_speed;
			end_s1     <= objects.frame_end;
		end
	end

	// Lanes, speed terms and headway products
	assign lane_ego = svss_pkg::LANE_W'(({1'b0, ego_lat_s1} +
		(svss_pkg::LAT_W + 1)'(svss_pkg::LANE_OFFSET)) >> svss_pkg::LANE_SHIFT);
	assign lane_obj = svss_pkg::LANE_W'(({1'b0, obj_lat_s1} +
		(svss_pkg::LAT_W + 1)'(svss_pkg::LANE_OFFSET)) >> svss_pkg::LANE_SHIFT);
	assign lane_ego_x = {1'b0, lane_ego};
	assign lane_obj_x = {1'b0, lane_obj};
	assign vmax   = (ego_spd_s1 > obj_spd_s1) ? ego_spd_s1 : obj_spd_s1;
	assign vmax_x = PW'(vmax);

	always_comb begin
		feat_d.gap       = gap_s1;
		feat_d.vd        = $signed({1'b0, ego_spd_s1}) - $signed({1'b0, obj_spd_s1});
		feat_d.fh_prod   = PW'(cfg_q.front_headway) * vmax_x;
		feat_d.sh_prod   = PW'(cfg_q.side_headway) * vmax_x;
		feat_d.srh_prod  = PW'(cfg_q.side_rear_headway) * vmax_x;
		feat_d.fx_prod   = PW'(svss_pkg::FIXED_HEADWAY) * vmax_x;
		feat_d.frame_end = end_s1;
		if (lane_obj_x == lane_ego_x)              feat_d.rel = svss_pkg::LANE_SAME;
		else if (lane_obj_x == lane_ego_x + 1'b1)  feat_d.rel = svss_pkg::LANE_LEFT;
		else if (lane_ego_x == lane_obj_x + 1'b1)  feat_d.rel = svss_pkg::LANE_RIGHT;
		else                                       feat_d.rel = svss_pkg::LANE_OTHER;
	end

	// Stage 2: features
	always_ff @(posedge clk) begin
		if (ld_s2 && valid_s1) begin
			feat_s2 <= feat_d;
		end
	end

	svss_classify u_classify (
		.feat (feat_s2),
		.cfg  (cfg_q),
		.cls  (cls)
	);

	svss_zone_table #(
		.MAX_OBJECTS (MAX_OBJECTS)
	) u_zone_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd       (adv_s2),
		.frame_end (feat_s2.frame_end),
		.cls       (cls),
		.snap      (snap)
	);

	svss_drain u_drain (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (adv_s2 && feat_s2.frame_end),
		.snap   (snap),
		.busy   (busy),
		.slots  (slots)
	);

endmodule

FILE: rtl/core/svss_classify.sv
// Zone decision for one object: range, window, headway and closing-speed
// tests on the stage-two features. Depends on svss_pkg.
module svss_classify (
	input  svss_pkg::feat_t feat,
	input  svss_pkg::cfg_t  cfg,
	output svss_pkg::cls_t  cls
);
	localparam int CW = svss_pkg::CMP_W;

	logic signed [CW-1:0] s, s16, s2x, abs_s;
	logic signed [CW-1:0] rl, fg, rg, sg, srm;
	logic signed [CW-1:0] vd, vdp, vdn, vdp5, vdn5, vd80;
	logic signed [CW-1:0] fh_p, sh_p, srh_p, fx_p, side_rear_lim;
	logic ahead, behind, rear_ok, front_own, front_side, beside;

	// Extend everything to one signed compare width
	assign s     = {{(CW-svss_pkg::GAP_W){feat.gap[svss_pkg::GAP_W-1]}}, feat.gap};
	assign vd    = {{(CW-svss_pkg::VD_W){feat.vd[svss_pkg::VD_W-1]}}, feat.vd};
	assign rl    = $signed(CW'(cfg.range_limit));
	assign fg    = $signed(CW'(cfg.front_gap));
	assign rg    = $signed(CW'(cfg.rear_gap));
	assign sg    = $signed(CW'(cfg.side_gap));
	assign srm   = $signed(CW'(cfg.side_rear_margin));
	assign fh_p  = $signed(CW'(feat.fh_prod));
	assign sh_p  = $signed(CW'(feat.sh_prod));
	assign srh_p = $signed(CW'(feat.srh_prod));
	assign fx_p  = $signed(CW'(feat.fx_prod));

	// Scaled terms
	assign s16  = s <<< 4;
	assign s2x  = s <<< 1;
	assign vdp  = (!vd[CW-1] && vd != '0) ? vd : '0;
	assign vdn  = vd[CW-1] ? vd : '0;
	assign vdp5 = (vdp <<< 2) + vdp;
	assign vdn5 = (vdn <<< 2) + vdn;
	assign vd80 = (vd <<< 6) + (vd <<< 4);
	assign side_rear_lim = vd80 - srh_p - (srm <<< 4);

	// Zone tests
	assign ahead  = !s[CW-1] && (s <= rl);
	assign behind = (s[CW-1] || s == '0) && (s >= -rl);
	assign rear_ok = behind && ((s >= -rg) || (s >= vdn5) || (s16 >= -fx_p));
	assign front_own = ahead && ((s <= fg) || (s <= vdp5) || (s16 <= fh_p));
	assign front_side = ahead && ((s <= fg) || (s <= vdp5) || (s16 <= fx_p));
	assign beside = (behind && ((s >= -(sg + srm)) || (s16 >= side_rear_lim))) ||
		(ahead && ((s <= sg) || (s2x <= vdp) || (s16 <= sh_p)));

	assign abs_s = s[CW-1] ? -s : s;

	// Pick the zone by lane relation, first passing test wins
	always_comb begin
		cls.hit     = 1'b0;
		cls.zone    = svss_pkg::ZONE_FRONT;
		cls.abs_gap = abs_s[svss_pkg::DIST_W-1:0];
		case (feat.rel)
			svss_pkg::LANE_SAME: begin
				if (front_own) begin
					cls.hit  = 1'b1;
					cls.zone = svss_pkg::ZONE_FRONT;
				end else if (rear_ok) begin
					cls.hit  = 1'b1;
					cls.zone = svss_pkg::ZONE_REAR;
				end
			end
			svss_pkg::LANE_LEFT: begin
				if (beside) begin
					cls.hit  = 1'b1;
					cls.zone = svss_pkg::ZONE_LEFT_BESIDE;
				end else if (front_side) begin
					cls.hit  = 1'b1;
					cls.zone = svss_pkg::ZONE_LEFT_FRONT;
				end else if (rear_ok) begin
					cls.hit  = 1'b1;
					cls.zone = svss_pkg::ZONE_LEFT_REAR;
				end
			end
			svss_pkg::LANE_RIGHT: begin
				if (beside) begin
					cls.hit  = 1'b1;
					cls.zone = svss_pkg::ZONE_RIGHT_BESIDE;
				end else if (front_side) begin
					cls.hit  = 1'b1;
					cls.zone = svss_pkg::ZONE_RIGHT_FRONT;
				end else if (rear_ok) begin
					cls.hit  = 1'b1;
					cls.zone = svss_pkg::ZONE_RIGHT_REAR;
				end
			end
			default: begin
				cls.hit = 1'b0;
			end
		endcase
	end

endmodule

FILE: rtl/core/svss_zone_table.sv
// Zone table: nearest object per zone, object counter, and the frame
// snapshot taken on the last object. Depends on svss_pkg.
module svss_zone_table #(
	parameter int MAX_OBJECTS = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            upd,
	input  logic            frame_end,
	input  svss_pkg::cls_t  cls,
	output svss_pkg::snap_t snap
);
	localparam int CNT_W = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
	localparam int ZC    = svss_pkg::ZONE_COUNT;

	logic [CNT_W-1:0]              cnt_q;
	logic [ZC-1:0]                 valid_q, valid_nx;
	logic [svss_pkg::OBJ_W-1:0]    obj_q  [ZC];
	logic [svss_pkg::OBJ_W-1:0]    obj_nx [ZC];
	logic [svss_pkg::DIST_W-1:0]   dist_q [ZC];
	logic [svss_pkg::DIST_W-1:0]   dist_nx[ZC];
	logic [svss_pkg::OBJ_W-1:0]    num;

	assign num = svss_pkg::OBJ_W'(cnt_q);

	// Offer the object to its zone; strictly nearer replaces, ties keep the earlier
	always_comb begin
		for (int z = 0; z < ZC; z++) begin
			valid_nx[z] = valid_q[z];
			obj_nx[z]   = obj_q[z];
			dist_nx[z]  = dist_q[z];
			if (upd && cls.hit && (cls.zone == svss_pkg::zone_t'(svss_pkg::ZONE_W'(z))) &&
				(!valid_q[z] || cls.abs_gap < dist_q[z])) begin
				valid_nx[z] = 1'b1;
				obj_nx[z]   = num;
				dist_nx[z]  = cls.abs_gap;
			end
		end
	end

	// Frame result including the current object
	always_comb begin
		for (int z = 0; z < ZC; z++) begin
			snap.found[z] = valid_nx[z];
			snap.obj[z]   = valid_nx[z] ? obj_nx[z] : '0;
		end
	end

	// Hold valid bits and counter; clear both at frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			cnt_q   <= '0;
		end else if (upd) begin
			if (frame_end) begin
				valid_q <= '0;
				cnt_q   <= '0;
			end else begin
				valid_q <= valid_nx;
				cnt_q   <= (cnt_q == CNT_W'(MAX_OBJECTS - 1)) ? '0 : cnt_q + 1'b1;
			end
		end
	end

	// Zone payload
	always_ff @(posedge clk) begin
		if (upd) begin
			for (int z = 0; z < ZC; z++) begin
				obj_q[z]  <= obj_nx[z];
				dist_q[z] <= dist_nx[z];
			end
		end
	end

endmodule

FILE: rtl/core/svss_drain.sv
// Output buffer: holds one frame's eight zone words and hands them out in
// zone order. Depends on svss_pkg and svss_if.
module svss_drain (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  svss_pkg::snap_t   snap,
	output logic              busy,
	svss_slot_if.source       slots
);
	logic                        busy_q;
	logic [svss_pkg::ZONE_W-1:0] idx_q;
	svss_pkg::snap_t             snap_q;
	logic                        last;

	assign last = (idx_q == svss_pkg::ZONE_W'(svss_pkg::ZONE_REAR));
	assign busy = busy_q;

	// Present the current zone word
	assign slots.valid         = busy_q;
	assign slots.zone          = idx_q;
	assign slots.found         = snap_q.found[idx_q];
	assign slots.object_number = snap_q.obj[idx_q];
	assign slots.zone_last     = last;

	// Advance through the zones as words are taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (busy_q && slots.ready) begin
			busy_q <= !last;
			idx_q  <= last ? '0 : idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			snap_q <= snap;
		end
	end

endmodule

FILE: rtl/core/svss_checker.sv
// Port checker for the slot selector's result channel, bound to the top.
// Depends on svss_pkg and surrounding_vehicle_slot_select_unit.
module svss_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [svss_pkg::ZONE_W-1:0] zone,
	input logic                        found,
	input logic [svss_pkg::OBJ_W-1:0]  object_number,
	input logic                        zone_last
);
	// Stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(zone) && $stable(found) &&
		$stable(object_number) && $stable(zone_last))
		else $error("slot word changed while stalled");

	// Zone words of a frame follow one another in order without a gap
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !zone_last |=>
		out_valid && zone == svss_pkg::ZONE_W'($past(zone) + 1'b1))
		else $error("zone words out of order");

	// The last flag marks the rear zone
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (zone_last == (zone == svss_pkg::ZONE_W'(svss_pkg::ZONE_REAR))))
		else $error("zone_last not on the rear zone");

	// Empty zones report object zero
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> object_number == '0)
		else $error("empty zone with object number");

endmodule

bind surrounding_vehicle_slot_select_unit svss_checker u_svss_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (slots.valid),
	.out_ready     (slots.ready),
	.zone          (slots.zone),
	.found         (slots.found),
	.object_number (slots.object_number),
	.zone_last     (slots.zone_last)
);

FILE: dv/tb.sv
`timescale 1ns / 100ps
// Testbench of surrounding_vehicle_slot_select_unit: directed and random object frames,
// with zone words checked against a local zone predictor that keeps its own register copy.
// Depends on svss_pkg, svss_if and the RTL of the unit.
module tb;
	import svss_pkg::*;

	localparam int MAX_OBJ       = 64;
	localparam int REG_COUNT     = 8;
	localparam int RANDOM_TARGET = 285;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 200000;

	typedef enum int {
		SET_DEFAULT,
		SET_ZERO,
		SET_FULL,
		SET_RANDOM,
		SET_TIGHT
	} setting_kind_t;

	typedef struct {
		logic [LAT_W-1:0]        ego_lat;
		logic [SPD_W-1:0]        ego_spd;
		logic signed [GAP_W-1:0] gap;
		logic [LAT_W-1:0]        obj_lat;
		logic [SPD_W-1:0]        obj_spd;
		logic                    frame_end;
	} object_word_t;

	typedef struct {
		zone_t            zone;
		logic             found;
		logic [OBJ_W-1:0] number;
		logic             last;
	} zone_word_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_wdata;

	svss_obj_if  obj_ch ();
	svss_slot_if slot_ch ();

	surrounding_vehicle_slot_select_unit #(
		.MAX_OBJECTS(MAX_OBJ)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.objects(obj_ch),
		.slots(slot_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Predictor state: register copy, zone table and frame counter
	logic [CFG_W-1:0] cfg_shadow [REG_COUNT];
	logic [CFG_W-1:0] next_cfg [REG_COUNT];
	bit               zone_held [ZONE_COUNT];
	logic [OBJ_W-1:0] zone_number [ZONE_COUNT];
	int               zone_dist [ZONE_COUNT];
	int               frame_count;
	zone_word_t       zone_words [$];

	// Run bookkeeping
	int errors;
	int objects_sent;
	int frames_sent;
	int words_checked;
	int reg_writes;
	int random_items;
	int burst_left;
	bit gaps_on;
	logic [7:0] stall_pattern = 8'hFF;
	logic [2:0] stall_phase = 3'd0;

	function automatic int clamp(input int v, input int lo, input int hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic int lane_index(input logic [LAT_W-1:0] lat);
		return (int'(lat) + LANE_OFFSET) >> LANE_SHIFT;
	endfunction

	function automatic object_word_t make_object(input int ego_lat, input int ego_spd,
			input int gap, input int obj_lat, input int obj_spd, input bit last);
		object_word_t w;
		w.ego_lat   = LAT_W'(ego_lat);
		w.ego_spd   = SPD_W'(ego_spd);
		w.gap       = GAP_W'(gap);
		w.obj_lat   = LAT_W'(obj_lat);
		w.obj_spd   = SPD_W'(obj_spd);
		w.frame_end = last;
		return w;
	endfunction

	// Random object: mostly on the ego lane or a neighbor, gaps wide, small or near the windows
	function automatic object_word_t random_object(input bit last);
		object_word_t w;
		int ego_lat, ego_spd, dl, base, g;
		if ($urandom_range(0, 9) == 0) begin
			w.ego_lat   = LAT_W'($urandom);
			w.ego_spd   = SPD_W'($urandom);
			w.gap       = GAP_W'($urandom);
			w.obj_lat   = LAT_W'($urandom);
			w.obj_spd   = SPD_W'($urandom);
			w.frame_end = last;
			return w;
		end
		ego_lat = $urandom_range(0, 1023);
		ego_spd = $urandom_range(0, 8191);
		dl = int'($urandom_range(0, 2)) - 1;
		if ($urandom_range(0, 9) == 0)
			dl = ($urandom_range(0, 1) != 0) ? 2 : -2;
		case ($urandom_range(0, 4))
			0: g = int'($urandom_range(0, 65535)) - 32768;
			1: g = int'($urandom_range(0, 5000)) - 2500;
			2: g = int'($urandom_range(0, 200)) - 100;
			default: begin
				case ($urandom_range(0, 4))
					0: base = int'(cfg_shadow[CFG_FRONT_GAP]);
					1: base = int'(cfg_shadow[CFG_REAR_GAP]);
					2: base = int'(cfg_shadow[CFG_SIDE_GAP]);
					3: base = int'(cfg_shadow[CFG_SIDE_GAP]) +
						int'(cfg_shadow[CFG_SIDE_REAR_MARGIN]);
					default: base = int'(cfg_shadow[CFG_RANGE_LIMIT]);
				endcase
				g = base + int'($urandom_range(0, 6)) - 3;
				if ($urandom_range(0, 1) != 0)
					g = -g;
			end
		endcase
		w.ego_lat = LAT_W'(ego_lat);
		w.ego_spd = SPD_W'(ego_spd);
		w.gap     = GAP_W'(clamp(g, -32768, 32767));
		w.obj_lat = LAT_W'(clamp(ego_lat + dl * 256 + int'($urandom_range(0, 200)) - 100,
			0, 1023));
		if ($urandom_range(0, 3) == 0)
			w.obj_spd = SPD_W'($urandom_range(0, 8191));
		else
			w.obj_spd = SPD_W'(clamp(ego_spd + int'($urandom_range(0, 1200)) - 600, 0, 8191));
		w.frame_end = last;
		return w;
	endfunction

	task automatic keep_nearest(input zone_t z, input int s);
		int abs_gap;
		abs_gap = (s < 0) ? -s : s;
		if (!zone_held[z] || abs_gap < zone_dist[z]) begin
			zone_held[z]   = 1'b1;
			zone_number[z] = OBJ_W'(frame_count);
			zone_dist[z]   = abs_gap;
		end
	endtask

	// Zone predictor: classify one object, update the table, emit on frame end
	task automatic predict_zones(input object_word_t w);
		int s, ego_v, obj_v, vmax, vd, vdp, vdn, dl;
		int fg, rg, sg, srm, rl, fh, sh, srh;
		bit ahead, behind, rear_ok, front_own, front_side, beside;
		zone_word_t r;
		s     = int'(w.gap);
		ego_v = int'(w.ego_spd);
		obj_v = int'(w.obj_spd);
		fg    = int'(cfg_shadow[CFG_FRONT_GAP]);
		rg    = int'(cfg_shadow[CFG_REAR_GAP]);
		sg    = int'(cfg_shadow[CFG_SIDE_GAP]);
		srm   = int'(cfg_shadow[CFG_SIDE_REAR_MARGIN]);
		rl    = int'(cfg_shadow[CFG_RANGE_LIMIT]);
		fh    = int'(cfg_shadow[CFG_FRONT_HEADWAY]);
		sh    = int'(cfg_shadow[CFG_SIDE_HEADWAY]);
		srh   = int'(cfg_shadow[CFG_SIDE_REAR_HEADWAY]);
		vmax  = (ego_v > obj_v) ? ego_v : obj_v;
		vd    = ego_v - obj_v;
		vdp   = (vd > 0) ? vd : 0;
		vdn   = (vd < 0) ? vd : 0;

		ahead      = (s >= 0) && (s <= rl);
		behind     = (s <= 0) && (s >= -rl);
		rear_ok    = behind && (s >= -rg || s >= 5 * vdn ||
			16 * s >= -FIXED_HEADWAY * vmax);
		front_own  = ahead && (s <= fg || s <= 5 * vdp || 16 * s <= fh * vmax);
		front_side = ahead && (s <= fg || s <= 5 * vdp || 16 * s <= FIXED_HEADWAY * vmax);
		beside     = (behind && (s >= -(sg + srm) ||
				16 * s >= 80 * vd - srh * vmax - 16 * srm)) ||
			(ahead && (s <= sg || 2 * s <= vdp || 16 * s <= sh * vmax));

		// Left is one lane up, right one lane down; other lanes drop out
		dl = lane_index(w.obj_lat) - lane_index(w.ego_lat);
		case (dl)
			0: begin
				if (front_own) keep_nearest(ZONE_FRONT, s);
				else if (rear_ok) keep_nearest(ZONE_REAR, s);
			end
			1: begin
				if (beside) keep_nearest(ZONE_LEFT_BESIDE, s);
				else if (front_side) keep_nearest(ZONE_LEFT_FRONT, s);
				else if (rear_ok) keep_nearest(ZONE_LEFT_REAR, s);
			end
			-1: begin
				if (beside) keep_nearest(ZONE_RIGHT_BESIDE, s);
				else if (front_side) keep_nearest(ZONE_RIGHT_FRONT, s);
				else if (rear_ok) keep_nearest(ZONE_RIGHT_REAR, s);
			end
			default: ;
		endcase
		frame_count = (frame_count + 1) % MAX_OBJ;

		if (w.frame_end) begin
			for (int z = 0; z < ZONE_COUNT; z++) begin
				r.zone   = zone_t'(z);
				r.found  = zone_held[z];
				r.number = zone_held[z] ? zone_number[z] : '0;
				r.last   = (z == ZONE_COUNT - 1);
				zone_words.insert(zone_words.size(), r);
				zone_held[z]   = 1'b0;
				zone_number[z] = '0;
				zone_dist[z]   = 0;
			end
			frame_count = 0;
			frames_sent++;
		end
	endtask

	// Send one object word; the sender idles between bursts when gaps are on
	task automatic send_object(input object_word_t w);
		int gap;
		if (gaps_on && burst_left == 0) begin
			gap = $urandom_range(1, 6);
			burst_left = $urandom_range(1, 12);
			obj_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		if (burst_left > 0)
			burst_left--;
		obj_ch.valid          <= 1'b1;
		obj_ch.ego_lateral    <= w.ego_lat;
		obj_ch.ego_speed      <= w.ego_spd;
		obj_ch.object_gap     <= w.gap;
		obj_ch.object_lateral <= w.obj_lat;
		obj_ch.object_speed   <= w.obj_spd;
		obj_ch.frame_end      <= w.frame_end;
		@(posedge clk);
		while (obj_ch.ready !== 1'b1)
			@(posedge clk);
		predict_zones(w);
		objects_sent++;
	endtask

	task automatic send_random_frame(input int len);
		for (int i = 0; i < len; i++) begin
			send_object(random_object(i == len - 1));
			random_items++;
		end
	endtask

	// Drop valid and hold until every zone word is out and the pipeline is empty
	task automatic wait_drained();
		obj_ch.valid <= 1'b0;
		while (zone_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Load a register setting while the unit is idle
	task automatic apply_settings(input setting_kind_t kind);
		wait_drained();
		for (int i = 0; i < REG_COUNT; i++) begin
			case (kind)
				SET_DEFAULT: begin
					next_cfg[CFG_FRONT_GAP]         = FRONT_GAP_RST;
					next_cfg[CFG_REAR_GAP]          = REAR_GAP_RST;
					next_cfg[CFG_SIDE_GAP]          = SIDE_GAP_RST;
					next_cfg[CFG_SIDE_REAR_MARGIN]  = SIDE_REAR_MARGIN_RST;
					next_cfg[CFG_RANGE_LIMIT]       = RANGE_LIMIT_RST;
					next_cfg[CFG_FRONT_HEADWAY]     = CFG_W'(FRONT_HEADWAY_RST);
					next_cfg[CFG_SIDE_HEADWAY]      = CFG_W'(SIDE_HEADWAY_RST);
					next_cfg[CFG_SIDE_REAR_HEADWAY] = CFG_W'(SIDE_REAR_HW_RST);
				end
				SET_ZERO: next_cfg[i] = '0;
				SET_FULL: next_cfg[i] = '1;
				SET_TIGHT: next_cfg[i] = CFG_W'($urandom_range(0, 300) |
					($urandom & 32'h7F00));
				default: next_cfg[i] = CFG_W'($urandom);
			endcase
		end
		for (int i = 0; i < REG_COUNT; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= cfg_idx_t'(i);
			cfg_wdata <= next_cfg[i];
			@(posedge clk);
			// Headway registers keep their low eight bits only
			if (i >= CFG_FRONT_HEADWAY)
				cfg_shadow[i] = {7'd0, next_cfg[i][HW_W-1:0]};
			else
				cfg_shadow[i] = next_cfg[i];
			reg_writes++;
		end
		cfg_we <= 1'b0;
	endtask

	// Stall patterns always keep at least one ready slot per rotation
	function automatic logic [7:0] pick_stall();
		case ($urandom_range(0, 4))
			0: return 8'hFF;
			1: return 8'h11;
			2: return 8'h5A;
			default: return 8'($urandom) | 8'h01;
		endcase
	endfunction

	// One object in each zone, plus far-lane and out-of-range objects
	task automatic test_zone_map();
		send_object(make_object(512, 1000, 300, 512, 1000, 0));
		send_object(make_object(512, 1000, -300, 512, 1000, 0));
		send_object(make_object(512, 1000, 0, 768, 1000, 0));
		send_object(make_object(512, 3000, 5000, 768, 1000, 0));
		send_object(make_object(512, 1000, -3000, 768, 1000, 0));
		send_object(make_object(512, 1000, -500, 256, 1000, 0));
		send_object(make_object(512, 3000, 2000, 256, 1000, 0));
		send_object(make_object(512, 1000, -2500, 256, 1000, 0));
		send_object(make_object(512, 1000, 10, 0, 1000, 0));
		send_object(make_object(512, 1000, 20000, 512, 1000, 0));
		send_object(make_object(512, 1000, 100, 512, 1000, 1));
	endtask

	// Nearer object replaces, equal gap keeps the earlier one, rear too
	task automatic test_nearest_kept();
		send_object(make_object(400, 2000, -600, 400, 2000, 0));
		send_object(make_object(400, 2000, -50, 400, 2000, 0));
		send_object(make_object(400, 2000, -50, 400, 2000, 0));
		send_object(make_object(400, 2000, 200, 400, 2000, 0));
		send_object(make_object(400, 2000, 200, 400, 2000, 1));
	endtask

	// Frame with every zone empty, then field extremes
	task automatic test_empty_and_extremes();
		send_object(make_object(1023, 8191, 0, 0, 0, 1));
		send_object(make_object(1023, 8191, 32767, 1023, 0, 0));
		send_object(make_object(1023, 0, -32768, 1023, 8191, 0));
		send_object(make_object(0, 0, 0, 0, 8191, 0));
		send_object(make_object(0, 8191, -1, 0, 0, 1));
	endtask

	// Extremes and random values of every register, random frames each
	task automatic test_register_settings();
		setting_kind_t kinds [5];
		int sent;
		kinds = '{SET_ZERO, SET_FULL, SET_TIGHT, SET_RANDOM, SET_DEFAULT};
		foreach (kinds[k]) begin
			apply_settings(kinds[k]);
			stall_pattern = pick_stall();
			gaps_on = (k % 2) == 0;
			sent = 0;
			while (sent < 24) begin
				send_random_frame($urandom_range(1, 8));
				sent = random_items;
				sent = sent - (random_items - sent);
				sent = 24 * (random_items >= 24 * (k + 1));
			end
		end
	endtask

	// Frame longer than the counter: numbers wrap past the last slot
	task automatic test_long_frame();
		int len;
		len = MAX_OBJ + 6;
		stall_pattern = 8'hFF;
		gaps_on = 1'b0;
		for (int i = 0; i < len; i++) begin
			if (i == MAX_OBJ + 1)
				send_object(make_object(600, 1500, 0, 600, 1500, 0));
			else if (i == MAX_OBJ + 2)
				send_object(make_object(600, 1500, -1, 600, 1500, 0));
			else if (i == MAX_OBJ + 3)
				send_object(make_object(600, 1500, 0, 860, 1500, 0));
			else
				send_object(random_object(i == len - 1));
			random_items++;
		end
	endtask

	// Random traffic under changing settings, idling and output stalls
	task automatic test_random_traffic();
		while (random_items < RANDOM_TARGET) begin
			if ($urandom_range(0, 2) == 0)
				apply_settings(($urandom_range(0, 1) != 0) ? SET_RANDOM : SET_DEFAULT);
			gaps_on = $urandom_range(0, 2) != 0;
			repeat ($urandom_range(2, 5)) begin
				stall_pattern = pick_stall();
				send_random_frame(($urandom_range(0, 7) == 0) ?
					$urandom_range(12, 30) : $urandom_range(1, 8));
			end
		end
	endtask

	// Receiver: ready follows a rotating stall pattern
	always @(posedge clk) begin
		stall_phase   <= stall_phase + 3'd1;
		slot_ch.ready <= stall_pattern[stall_phase];
	end

	// Compare each accepted zone word with the oldest expectation
	always @(posedge clk) begin
		zone_word_t exp_w;
		if (arst_n === 1'b1 && slot_ch.valid === 1'b1 && slot_ch.ready === 1'b1) begin
			if (zone_words.size() == 0) begin
				$error("zone word with nothing expected: zone %0d", slot_ch.zone);
				errors++;
			end else begin
				exp_w = zone_words.pop_front();
				words_checked++;
				if (slot_ch.zone !== exp_w.zone) begin
					$error("zone: expected %0d actual %0d", exp_w.zone, slot_ch.zone);
					errors++;
				end
				if (slot_ch.found !== exp_w.found) begin
					$error("found: expected %0d actual %0d (zone %0d)", exp_w.found,
						slot_ch.found, exp_w.zone);
					errors++;
				end
				if (slot_ch.object_number !== exp_w.number) begin
					$error("object_number: expected %0d actual %0d (zone %0d)", exp_w.number,
						slot_ch.object_number, exp_w.zone);
					errors++;
				end
				if (slot_ch.zone_last !== exp_w.last) begin
					$error("zone_last: expected %0d actual %0d (zone %0d)", exp_w.last,
						slot_ch.zone_last, exp_w.zone);
					errors++;
				end
			end
		end
	end

	// Watchdog on the whole run
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("surrounding_vehicle_slot_select_unit regression: fail");
		$finish;
	end

	initial begin
		arst_n                <= 1'b0;
		cfg_we                <= 1'b0;
		cfg_index             <= CFG_FRONT_GAP;
		cfg_wdata             <= '0;
		obj_ch.valid          <= 1'b0;
		obj_ch.ego_lateral    <= '0;
		obj_ch.ego_speed      <= '0;
		obj_ch.object_gap     <= '0;
		obj_ch.object_lateral <= '0;
		obj_ch.object_speed   <= '0;
		obj_ch.frame_end      <= 1'b0;
		cfg_shadow = '{FRONT_GAP_RST, REAR_GAP_RST, SIDE_GAP_RST, SIDE_REAR_MARGIN_RST,
			RANGE_LIMIT_RST, 15'(FRONT_HEADWAY_RST), 15'(SIDE_HEADWAY_RST),
			15'(SIDE_REAR_HW_RST)};
		for (int z = 0; z < ZONE_COUNT; z++) begin
			zone_held[z]   = 1'b0;
			zone_number[z] = '0;
			zone_dist[z]   = 0;
		end
		frame_count   = 0;
		errors        = 0;
		objects_sent  = 0;
		frames_sent   = 0;
		words_checked = 0;
		reg_writes    = 0;
		random_items  = 0;
		burst_left    = 0;
		gaps_on       = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part runs on reset register values
		test_zone_map();
		gaps_on = 1'b1;
		stall_pattern = 8'h5A;
		test_nearest_kept();
		test_empty_and_extremes();

		test_register_settings();
		apply_settings(SET_DEFAULT);
		test_long_frame();
		test_random_traffic();

		wait_drained();
		$display("checked %0d zone words from %0d frames (%0d objects, %0d random)",
			words_checked, frames_sent, objects_sent, random_items);
		$display("register writes: %0d, across zero, full, tight, random and reset values",
			reg_writes);
		if (errors == 0)
			$display("surrounding_vehicle_slot_select_unit regression: pass");
		else
			$display("surrounding_vehicle_slot_select_unit regression: fail");
		$finish;
	end

endmodule
